>>> rtl/adf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package adf_pkg;

	// fixed field widths
	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 16;
	localparam int CFG_W     = 9;
	localparam int IDX_W     = 8;
	localparam int HDR_W     = 8;
	localparam int DATA_W    = 64;
	localparam int RES_W     = 19;  // 4-bit residual shifted left by up to 15
	localparam int PROD_W    = 32;
	localparam int ACC_W     = 33;
	localparam int Q_SHIFT   = 11;
	localparam int VAL_W     = ACC_W - Q_SHIFT + 1;

	localparam int FRAME_N   = 16;
	localparam int CNT_W     = 4;
	localparam int BOOK_SPAN = 256;  // reach of an 8-bit codebook index

	// stream payload
	localparam int IN_W      = 136;
	localparam int OUT_W     = 16;

	localparam logic OP_COEF  = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	localparam logic [1:0] START_KEEP = 2'd0;
	localparam logic [1:0] START_ZERO = 2'd1;
	localparam logic [1:0] START_LOOP = 2'd2;

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sh8000;

	// one sample slot leaving the issue stage
	typedef struct packed {
		logic                    vld;
		logic                    first;
		logic                    second;
		logic                    last;
		logic                    ovr;    // history comes from the init values
		logic                    c0_ok;
		logic                    c1_ok;
		logic signed [RES_W-1:0] res;
	} issue_t;

	typedef struct packed {
		logic                       vld;
		logic                       last;
		logic signed [SAMPLE_W-1:0] sample;
	} dp_out_t;

endpackage

`default_nettype wire

>>> rtl/adf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module adf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

>>> rtl/adf_sample_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module adf_sample_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                adv,
	input  wire adf_pkg::issue_t                     iss,
	input  wire logic signed [adf_pkg::COEF_W-1:0]   c0_raw,
	input  wire logic signed [adf_pkg::COEF_W-1:0]   c1_raw,
	input  wire logic signed [adf_pkg::SAMPLE_W-1:0] r_init,
	input  wire logic signed [adf_pkg::SAMPLE_W-1:0] o_init,
	output adf_pkg::dp_out_t                         dout
);
	import adf_pkg::*;

	issue_t                     iss_s1, iss_s2;
	logic signed [COEF_W-1:0]   c0_s2;
	logic signed [PROD_W-1:0]   p2_s2;
	logic signed [SAMPLE_W-1:0] hr_q, ho_q;

	logic signed [COEF_W-1:0]   c0, c1;
	logic signed [SAMPLE_W-1:0] h2_op, h1_op;
	logic signed [PROD_W-1:0]   p2, m0;
	logic signed [ACC_W-1:0]    acc;
	logic signed [VAL_W-1:0]    val;
	logic signed [SAMPLE_W-1:0] sat;

	// s1: coefficients arrive; older tap product is formed here and registered for s2
	assign c0 = iss_s1.c0_ok ? c0_raw : '0;
	assign c1 = iss_s1.c1_ok ? c1_raw : '0;

	// sample k-2 is hr_q while s2 holds sample k-1, else it sits in ho_q
	always_comb begin
		if (iss_s1.ovr && iss_s1.first) begin
			h2_op = o_init;
		end else if (iss_s1.ovr && iss_s1.second) begin
			h2_op = r_init;
		end else if (iss_s2.vld) begin
			h2_op = hr_q;
		end else begin
			h2_op = ho_q;
		end
	end

	assign p2 = c1 * h2_op;

	// s2: recent tap, floor shift, residual, saturate
	assign h1_op = (iss_s2.ovr && iss_s2.first) ? r_init : hr_q;
	assign m0    = c0_s2 * h1_op;
	assign acc   = ACC_W'(m0) + ACC_W'(p2_s2);
	assign val   = VAL_W'($signed(acc[ACC_W-1:Q_SHIFT])) + VAL_W'(iss_s2.res);

	always_comb begin
		if (val > VAL_W'(SAT_MAX)) begin
			sat = SAT_MAX;
		end else if (val < VAL_W'(SAT_MIN)) begin
			sat = SAT_MIN;
		end else begin
			sat = val[SAMPLE_W-1:0];
		end
	end

	assign dout.vld    = iss_s2.vld;
	assign dout.last   = iss_s2.last;
	assign dout.sample = sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
			iss_s2 <= '0;
			hr_q   <= '0;
			ho_q   <= '0;
		end else if (adv) begin
			iss_s1 <= iss;
			iss_s2 <= iss_s1;
			if (iss_s2.vld) begin
				hr_q <= sat;
				ho_q <= h1_op;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c0_s2 <= c0;
			p2_s2 <= p2;
		end
	end

endmodule

`default_nettype wire

>>> rtl/adpcm_frame_decoder.sv
// Frame beat: the first sample passes the issue stage, s1, s2 and the output register,
// then one sample per cycle while the output is not stalled. Frames of 16 samples run
// back to back; the issue counter gates acceptance and the sample datapath carries the
// history from each sample to the next. Coefficient beat: no result.
// Reset: async, active low; clears control, history and book_entries, then a clearing
// pass zeroes all min(BOOK_DEPTH, 256) codebook entries with s_tready low.
`timescale 1ns / 1ps
`default_nettype none

module adpcm_frame_decoder #(
	parameter int BOOK_DEPTH = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// book_entries
	input  wire logic                        cfg_we,
	input  wire logic [adf_pkg::CFG_W-1:0]   cfg_data,
	// tdata, low bit up: coef_index[7:0], coef_value[23:8], frame_header[31:24],
	// frame_data[95:32], small_mode[96], start_mode[98:97], loop_recent[114:99],
	// loop_older[130:115], zero pad[135:131]
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [adf_pkg::IN_W-1:0]    s_tdata,
	// tuser: op[0]
	input  wire logic                        s_tuser,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// tdata: sample[15:0]
	output logic      [adf_pkg::OUT_W-1:0]   m_tdata,
	output logic                             m_tlast
);
	import adf_pkg::*;

	localparam int MEM_DEPTH = (BOOK_DEPTH < BOOK_SPAN) ? BOOK_DEPTH : BOOK_SPAN;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam logic [CFG_W-1:0] MEM_DEPTH_C = CFG_W'(MEM_DEPTH);
	localparam logic [AW-1:0]    CLR_LAST    = AW'(MEM_DEPTH - 1);
	localparam logic [CNT_W-1:0] LAST_CNT    = CNT_W'(FRAME_N - 1);

	// input beat unpack
	logic                       in_op;
	logic [IDX_W-1:0]           in_idx;
	logic [COEF_W-1:0]          in_coef;
	logic [HDR_W-1:0]           in_hdr;
	logic [DATA_W-1:0]          in_data;
	logic                       in_small;
	logic [1:0]                 in_start;
	logic signed [SAMPLE_W-1:0] in_recent, in_older;

	assign in_op     = s_tuser;
	assign in_idx    = s_tdata[7:0];
	assign in_coef   = s_tdata[23:8];
	assign in_hdr    = s_tdata[31:24];
	assign in_data   = s_tdata[95:32];
	assign in_small  = s_tdata[96];
	assign in_start  = s_tdata[98:97];
	assign in_recent = s_tdata[114:99];
	assign in_older  = s_tdata[130:115];

	// control
	logic             clr_busy_q;
	logic [AW-1:0]    clr_cnt_q;
	logic [CFG_W-1:0] book_entries_q;
	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;

	// frame context, loaded on a decode beat
	logic [3:0]                 pred_q, shift_q;
	logic [DATA_W-1:0]          data_q;   // shifts left as residuals are issued
	logic                       small_q;
	logic                       ovr_q;
	logic signed [SAMPLE_W-1:0] r_init_q, o_init_q;

	// output register
	logic                       m_tvalid_q, m_tlast_q;
	logic [SAMPLE_W-1:0]        sample_q;

	logic    adv, s_acc, issue_done;
	issue_t  iss;
	dp_out_t dp_out;

	// whole sample pipe moves when the output register can take a beat
	assign adv        = !m_tvalid_q || m_tready;
	assign issue_done = busy_q && (cnt_q == LAST_CNT) && adv;
	// next frame may enter as the last sample of this one is issued
	assign s_tready   = !clr_busy_q && (!busy_q || issue_done);
	assign s_acc      = s_tvalid && s_tready;

	// ---- issue stage: codebook addresses and residual for sample cnt_q ----
	logic [IDX_W-1:0]        addr0, addr1;
	logic signed [3:0]       nib;
	logic signed [RES_W-1:0] nib_ext;

	assign addr0 = {pred_q, 1'b0, cnt_q[2:0]};
	assign addr1 = {pred_q, 1'b1, cnt_q[2:0]};

	// small mode: 2-bit residual from the top of the byte stream
	assign nib     = small_q ? {{2{data_q[DATA_W-1]}}, data_q[DATA_W-1:DATA_W-2]}
	                         : data_q[DATA_W-1:DATA_W-4];
	assign nib_ext = RES_W'(nib);

	assign iss.vld    = busy_q;
	assign iss.first  = (cnt_q == '0);
	assign iss.second = (cnt_q == CNT_W'(1));
	assign iss.last   = (cnt_q == LAST_CNT);
	assign iss.ovr    = ovr_q;
	// past the loaded entries or past the store, a coefficient reads zero
	assign iss.c0_ok  = ({1'b0, addr0} < book_entries_q) && ({1'b0, addr0} < MEM_DEPTH_C);
	assign iss.c1_ok  = ({1'b0, addr1} < book_entries_q) && ({1'b0, addr1} < MEM_DEPTH_C);
	assign iss.res    = nib_ext <<< shift_q;

	// ---- codebook ----
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [COEF_W-1:0] ram_wdata;
	logic [COEF_W-1:0] c0_raw, c1_raw;

	assign ram_we    = clr_busy_q
	                || (s_acc && (in_op == OP_COEF) && ({1'b0, in_idx} < MEM_DEPTH_C));
	assign ram_waddr = clr_busy_q ? clr_cnt_q : in_idx[AW-1:0];
	assign ram_wdata = clr_busy_q ? '0 : in_coef;

	adf_ram #(
		.WIDTH (COEF_W),
		.DEPTH (MEM_DEPTH)
	) u_book (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (adv),
		.raddr_a (addr0[AW-1:0]),
		.raddr_b (addr1[AW-1:0]),
		.rdata_a (c0_raw),
		.rdata_b (c1_raw)
	);

	adf_sample_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.iss    (iss),
		.c0_raw (c0_raw),
		.c1_raw (c1_raw),
		.r_init (r_init_q),
		.o_init (o_init_q),
		.dout   (dp_out)
	);

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q     <= 1'b1;
			clr_cnt_q      <= '0;
			book_entries_q <= '0;
			busy_q         <= 1'b0;
			cnt_q          <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == CLR_LAST) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				book_entries_q <= cfg_data;
			end
			if (s_acc && (in_op == OP_FRAME)) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q && adv) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				m_tvalid_q <= dp_out.vld;
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (s_acc && (in_op == OP_FRAME)) begin
			pred_q   <= in_hdr[7:4];
			shift_q  <= in_hdr[3:0];
			data_q   <= in_data;
			small_q  <= in_small;
			// start mode 3 keeps the history like mode 0
			ovr_q    <= (in_start == START_ZERO) || (in_start == START_LOOP);
			r_init_q <= (in_start == START_LOOP) ? in_recent : '0;
			o_init_q <= (in_start == START_LOOP) ? in_older : '0;
		end else if (busy_q && adv) begin
			data_q <= small_q ? (data_q << 2) : (data_q << 4);
		end
		if (adv) begin
			sample_q  <= dp_out.sample;
			m_tlast_q <= dp_out.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = sample_q;
	assign m_tlast  = m_tlast_q;

	// ---- assertions ----
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_tready)
		else $error("beat taken during codebook clear");

	a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (cnt_q != LAST_CNT)) |-> !s_tready)
		else $error("beat taken while frame still issuing");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && dp_out.vld) |=> m_tvalid)
		else $error("computed sample lost before output register");

	a_issue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && busy_q) |=> (busy_q && $stable(cnt_q)))
		else $error("issue counter moved during output stall");

endmodule

`default_nettype wire

>>> bench/adpcm_frame_decoder_tb.sv
`timescale 1ns / 1ps

module adpcm_frame_decoder_tb;
	import adf_pkg::*;

	localparam int BOOK_DEPTH  = 256;
	localparam int STALL_LIMIT = 5000;   // cycles without any beat before giving up
	localparam int HOLD_CYCLES = 400;    // long sink hold-off, fills the decoder up
	localparam int DRAIN_PAUSE = 10;     // settle time before a book_entries write
	localparam logic [1:0] START_SPARE = 2'd3;   // unused start mode, acts as keep

	typedef enum int {ROW_CFG, ROW_COEF, ROW_FRAME} row_kind_t;

	// one line of the directed plan
	typedef struct {
		row_kind_t               kind;
		logic [CFG_W-1:0]        entries;
		logic [IDX_W-1:0]        index;
		logic signed [15:0]      coef;
		logic [HDR_W-1:0]        hdr;
		logic [DATA_W-1:0]       bits;
		logic                    narrow;
		logic [1:0]              mode;
		logic signed [15:0]      recent;
		logic signed [15:0]      older;
		bit                      typed;      // all 16 samples equal typed_val
		logic signed [15:0]      typed_val;
	} plan_row_t;

	typedef struct {
		logic signed [15:0] sample;
		logic               last;
	} pcm_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tlast;

	// predictor state
	logic signed [15:0]   codebook [BOOK_DEPTH];
	logic [CFG_W-1:0]     book_entries;
	int                   hist_recent;
	int                   hist_older;

	pcm_t                 pcm_expected [$];
	int                   mismatches;
	int                   idle_cycles;
	bit                   sender_burst;   // no sender gaps in this phase
	bit                   hold_req;       // ask the sink for one long hold-off

	adpcm_frame_decoder #(
		.BOOK_DEPTH(BOOK_DEPTH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint tap_coef(input int idx);
		// indices past the loaded count (or the store) read as zero
		if (idx >= book_entries || idx >= BOOK_DEPTH) return 0;
		return longint'(codebook[idx]);
	endfunction

	// Decode one frame into 16 expected samples and update the history.
	task automatic decode_frame(input logic [HDR_W-1:0] hdr, input logic [DATA_W-1:0] bits,
			input logic narrow, input logic [1:0] mode,
			input logic signed [15:0] recent, input logic signed [15:0] older,
			input bit typed, input logic signed [15:0] typed_val);
		int     h1;
		int     h2;
		int     nib;
		int     pred;
		int     shift;
		longint acc;
		longint val;
		pcm_t   item;
		pred  = int'(hdr[7:4]);
		shift = int'(hdr[3:0]);
		case (mode)
			START_ZERO: begin
				h1 = 0;
				h2 = 0;
			end
			START_LOOP: begin
				h1 = recent;
				h2 = older;
			end
			default: begin
				h1 = hist_recent;
				h2 = hist_older;
			end
		endcase
		for (int s = 0; s < FRAME_N; s++) begin
			// 2-bit fields from bit 63 down, or nibbles high first
			if (narrow) begin
				nib = int'(bits[62 - 2 * s +: 2]);
				if (nib >= 2) nib -= 4;
			end else begin
				nib = int'(bits[60 - 4 * s +: 4]);
				if (nib >= 8) nib -= 16;
			end
			acc = tap_coef(pred * 16 + s % 8) * h1 + tap_coef(pred * 16 + 8 + s % 8) * h2;
			// arithmetic shift of a signed value is a floor divide
			val = (acc >>> Q_SHIFT) + longint'(nib) * (longint'(1) << shift);
			if (val > 32767) val = 32767;
			if (val < -32768) val = -32768;
			h2 = h1;
			h1 = int'(val);
			item.sample = typed ? typed_val : 16'(h1);
			item.last   = (s == FRAME_N - 1);
			pcm_expected.push_back(item);
		end
		hist_recent = h1;
		hist_older  = h2;
	endtask

	// ---------------------------------------------------------------- driving

	function automatic logic [IN_W-1:0] pack_fields(input logic [IDX_W-1:0] index,
			input logic signed [15:0] coef, input logic [HDR_W-1:0] hdr,
			input logic [DATA_W-1:0] bits, input logic narrow, input logic [1:0] mode,
			input logic signed [15:0] recent, input logic signed [15:0] older);
		return {5'b0, older, recent, mode, narrow, bits, hdr, coef, index};
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return $urandom_range(1, 3);
		return $urandom_range(12, 50);
	endfunction

	// Offer one beat from the falling edge, return once it is taken.
	task automatic send_beat(input logic op, input logic [IN_W-1:0] payload);
		int gap;
		gap = (sender_burst || $urandom_range(0, 99) < 55) ? 0 : pause_len();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = payload;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic load_coef(input logic [IDX_W-1:0] index, input logic signed [15:0] coef);
		send_beat(OP_COEF, pack_fields(index, coef, '0, '0, 1'b0, '0, '0, '0));
		codebook[index] = coef;
	endtask

	task automatic play_frame(input logic [HDR_W-1:0] hdr, input logic [DATA_W-1:0] bits,
			input logic narrow, input logic [1:0] mode,
			input logic signed [15:0] recent, input logic signed [15:0] older,
			input bit typed, input logic signed [15:0] typed_val);
		send_beat(OP_FRAME, pack_fields(8'($urandom), 16'($urandom), hdr, bits, narrow,
			mode, recent, older));
		decode_frame(hdr, bits, narrow, mode, recent, older, typed, typed_val);
	endtask

	// book_entries only changes with the decoder drained and quiet
	task automatic set_book_entries(input logic [CFG_W-1:0] value);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pcm_expected.size() != 0) @(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
		cfg_we   = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we   = 1'b0;
		book_entries = value;
	endtask

	function automatic plan_row_t cfg_row(input logic [CFG_W-1:0] value);
		plan_row_t r;
		r.kind      = ROW_CFG;
		r.entries   = value;
		r.index     = '0;
		r.coef      = '0;
		r.hdr       = '0;
		r.bits      = '0;
		r.narrow    = 1'b0;
		r.mode      = '0;
		r.recent    = '0;
		r.older     = '0;
		r.typed     = 1'b0;
		r.typed_val = '0;
		return r;
	endfunction

	function automatic plan_row_t coef_row(input logic [IDX_W-1:0] index,
			input logic signed [15:0] coef);
		plan_row_t r;
		r.kind      = ROW_COEF;
		r.entries   = '0;
		r.index     = index;
		r.coef      = coef;
		r.hdr       = '0;
		r.bits      = '0;
		r.narrow    = 1'b0;
		r.mode      = '0;
		r.recent    = '0;
		r.older     = '0;
		r.typed     = 1'b0;
		r.typed_val = '0;
		return r;
	endfunction

	function automatic plan_row_t frame_row(input logic [HDR_W-1:0] hdr,
			input logic [DATA_W-1:0] bits, input logic narrow, input logic [1:0] mode,
			input logic signed [15:0] recent, input logic signed [15:0] older,
			input bit typed, input logic signed [15:0] typed_val);
		plan_row_t r;
		r.kind      = ROW_FRAME;
		r.entries   = '0;
		r.index     = '0;
		r.coef      = '0;
		r.hdr       = hdr;
		r.bits      = bits;
		r.narrow    = narrow;
		r.mode      = mode;
		r.recent    = recent;
		r.older     = older;
		r.typed     = typed;
		r.typed_val = typed_val;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus

	initial begin : stimulus
		plan_row_t plan [$];
		logic [CFG_W-1:0] settings [10];
		logic signed [15:0] coef;
		logic [HDR_W-1:0] hdr;
		logic [1:0] mode;
		int r;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tuser      = 1'b0;
		s_tdata      = '0;
		sender_burst = 1'b0;
		hold_req     = 1'b0;
		mismatches   = 0;
		book_entries = '0;
		hist_recent  = 0;
		hist_older   = 0;
		foreach (codebook[i]) codebook[i] = '0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Empty book: samples are bare residuals, so saturation and the
		// narrow mode can be read off directly.
		plan.push_back(cfg_row(9'd0));
		plan.push_back(frame_row(8'h0F, 64'h7777_7777_7777_7777, 1'b0, START_ZERO,
			'0, '0, 1'b1, 16'sh7FFF));
		plan.push_back(frame_row(8'h0F, 64'h8888_8888_8888_8888, 1'b0, START_ZERO,
			'0, '0, 1'b1, -16'sh8000));
		plan.push_back(frame_row(8'h00, 64'h0, 1'b0, START_LOOP,
			16'sh7FFF, -16'sh8000, 1'b1, 16'sh0000));
		plan.push_back(frame_row(8'h00, 64'h1111_1111_1111_1111, 1'b0, START_KEEP,
			'0, '0, 1'b1, 16'sh0001));
		// narrow mode, low word must be ignored; spare start mode keeps history
		plan.push_back(frame_row(8'h00, 64'h5555_5555_DEAD_BEEF, 1'b1, START_SPARE,
			'0, '0, 1'b1, 16'sh0001));
		plan.push_back(frame_row(8'h03, 64'hFFFF_FFFF_0123_4567, 1'b1, START_ZERO,
			'0, '0, 1'b1, -16'sh0008));
		// coefficients at both ends of the store, extreme values at the low end
		plan.push_back(coef_row(8'd0, 16'sh7FFF));
		plan.push_back(coef_row(8'd8, -16'sh8000));
		plan.push_back(coef_row(8'd1, 16'sh0800));
		plan.push_back(coef_row(8'd9, -16'sh0400));
		plan.push_back(coef_row(8'd255, 16'sh4000));
		plan.push_back(coef_row(8'd240, -16'sh0800));
		// full book: predictor rows from here on
		plan.push_back(cfg_row(9'd256));
		plan.push_back(frame_row(8'h00, 64'h0, 1'b0, START_LOOP,
			16'sh7FFF, -16'sh8000, 1'b0, '0));
		plan.push_back(frame_row(8'h05, 64'h0123_4567_89AB_CDEF, 1'b0, START_KEEP,
			'0, '0, 1'b0, '0));
		plan.push_back(frame_row(8'h0F, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0, START_SPARE,
			'0, '0, 1'b0, '0));
		plan.push_back(frame_row(8'hFF, 64'h7F80_7F80_7F80_7F80, 1'b0, START_LOOP,
			-16'sh8000, 16'sh7FFF, 1'b0, '0));
		// partial book: index 8 still loaded, 9 and up read as zero
		plan.push_back(cfg_row(9'd9));
		plan.push_back(frame_row(8'h01, 64'h9A3C_E571_0F2B_86D4, 1'b0, START_LOOP,
			16'sd1000, -16'sd1000, 1'b0, '0));
		plan.push_back(frame_row(8'hF2, 64'h1234_5678_9ABC_DEF0, 1'b0, START_KEEP,
			'0, '0, 1'b0, '0));
		// count past the store depth
		plan.push_back(cfg_row(9'd511));
		plan.push_back(frame_row(8'hF4, 64'hC3A5_5A3C_0000_0000, 1'b1, START_ZERO,
			'0, '0, 1'b0, '0));
		plan.push_back(coef_row(8'd7, 16'sh1000));
		plan.push_back(frame_row(8'h00, 64'h7654_3210_FEDC_BA98, 1'b0, START_KEEP,
			'0, '0, 1'b0, '0));

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_CFG: begin
					set_book_entries(plan[i].entries);
				end
				ROW_COEF: begin
					load_coef(plan[i].index, plan[i].coef);
				end
				default: begin
					play_frame(plan[i].hdr, plan[i].bits, plan[i].narrow, plan[i].mode,
						plan[i].recent, plan[i].older, plan[i].typed, plan[i].typed_val);
				end
			endcase
		end

		// Random phases, each under its own book size. Frames mostly continue
		// the history so the recurrence runs across frames.
		settings = '{9'd256, 9'd0, 9'd32, 9'd511, 9'd0, 9'd256, 9'd0, 9'd0, 9'd144, 9'd256};
		settings[1] = 9'($urandom_range(1, 255));
		settings[4] = 9'($urandom_range(0, 256));
		settings[7] = 9'($urandom_range(0, 256));
		for (int phase = 0; phase < 10; phase++) begin
			set_book_entries(settings[phase]);
			sender_burst = (phase % 3 == 1);
			if (phase == 2) hold_req = 1'b1;
			repeat (35) begin
				if ($urandom_range(0, 99) < 30) begin
					// realistic Q11 taps half of the time, any 16-bit value otherwise
					if ($urandom_range(0, 1))
						coef = 16'($urandom_range(0, 8191) - 4096);
					else
						coef = 16'($urandom);
					load_coef(8'($urandom), coef);
				end else begin
					hdr = 8'($urandom);
					if ($urandom_range(0, 99) < 60) hdr[3:0] = 4'($urandom_range(0, 4));
					r = $urandom_range(0, 99);
					if (r < 50)      mode = START_KEEP;
					else if (r < 70) mode = START_ZERO;
					else if (r < 90) mode = START_LOOP;
					else             mode = START_SPARE;
					play_frame(hdr, {$urandom, $urandom}, 1'($urandom_range(0, 1)), mode,
						16'($urandom), 16'($urandom), 1'b0, '0);
				end
			end
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		while (pcm_expected.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// ---------------------------------------------------------------- sink

	// Random ready pattern: long open stretches and short or long stalls,
	// plus one long hold-off on request while the source keeps offering.
	initial begin : sink
		int n;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				@(negedge clk);
				m_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(0, 1)) begin
				n = $urandom_range(1, 60);
				@(negedge clk);
				m_tready = 1'b1;
				repeat (n - 1) @(negedge clk);
			end else begin
				n = pause_len();
				@(negedge clk);
				m_tready = 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %0s mismatch, expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// every sample beat is matched against the oldest expected sample
	always @(posedge clk) begin : sample_check
		pcm_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pcm_expected.size() == 0) begin
				report_mismatch("unexpected sample", 0, $signed(m_tdata));
			end else begin
				want = pcm_expected.pop_front();
				if (m_tdata !== want.sample)
					report_mismatch("sample", want.sample, $signed(m_tdata));
				if (m_tlast !== want.last)
					report_mismatch("tlast", want.last, m_tlast);
			end
		end
	end

	// watchdog: too long with no beat on either side
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

>>> adpcm_frame_decoder.f
rtl/adf_pkg.sv
rtl/adf_ram.sv
rtl/adf_sample_dp.sv
rtl/adpcm_frame_decoder.sv
bench/adpcm_frame_decoder_tb.sv
